// ===== rtl/arp_table_sequencer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the arpeggio table sequencer
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ARP_TABLE_SEQUENCER_ASSERT_SVH
`define ARP_TABLE_SEQUENCER_ASSERT_SVH

// Same-cycle implication
`define ATS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ATS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ats_pkg.sv =====
// ---------------------------------------------------------------------------
// ats_pkg
// Shared widths, row kind codes, operation codes and types of the
// arpeggio table sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

  // Table depth default
  localparam int unsigned TABLE_DEPTH = 256;

  // Field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned REL_W  = 12;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned PTR_W  = 9;
  localparam int unsigned CALC_W = PTR_W + 1;

  // Row kinds (codes 5..7 are stored and step like plain rows)
  localparam logic [KIND_W-1:0] KIND_RELATIVE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ABSOLUTE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GOTO     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SUSTAIN  = 3'd4;

  // Reset value of table_length
  localparam logic [LEN_W-1:0] LEN_RESET = 9'd2;

  // Operations
  typedef enum logic [OP_W-1:0] {
    OP_START   = 2'd0,
    OP_STEP    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_WRITE   = 2'd3
  } op_e;

  // One table row
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
  } row_t;

  localparam int unsigned ROW_W = KIND_W + VAL_W;

  // Sequencer state
  typedef struct packed {
    logic [PTR_W-1:0] ptr;   // two's complement, -1 after start
    logic             sus;
    logic             rel;
    logic [REL_W-1:0] cnt;
  } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/ats_ram.sv =====
// ---------------------------------------------------------------------------
// ats_ram
// Generic single-write, single-read RAM with registered read data.
// Read data holds while the read enable is low.
// ---------------------------------------------------------------------------
`default_nettype none

module ats_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ats_row_store.sv =====
// ---------------------------------------------------------------------------
// ats_row_store
// Note table: two RAM copies give two read ports; per-row valid bits make
// rows never written read as their reset contents.
// ---------------------------------------------------------------------------
`default_nettype none

module ats_row_store #(
  parameter int unsigned TABLE_DEPTH = ats_pkg::TABLE_DEPTH,
  localparam int unsigned AW         = $clog2(TABLE_DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  ats_pkg::row_t        wdata_i,
  input  wire logic            a_en_i,
  input  wire logic [AW-1:0]   a_addr_i,
  output ats_pkg::row_t        a_row_o,
  input  wire logic            b_en_i,
  input  wire logic [AW-1:0]   b_addr_i,
  output ats_pkg::row_t        b_row_o
);

  logic [TABLE_DEPTH-1:0] vld_q;
  logic                   a_vld_q, a_one_q;
  logic                   b_vld_q, b_one_q;
  logic [ats_pkg::ROW_W-1:0] a_raw, b_raw;

  // Valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // Valid and row-one flags follow the read data
  always_ff @(posedge clk_i) begin
    if (a_en_i) begin
      a_vld_q <= vld_q[a_addr_i];
      a_one_q <= (a_addr_i == AW'(1));
    end
    if (b_en_i) begin
      b_vld_q <= vld_q[b_addr_i];
      b_one_q <= (b_addr_i == AW'(1));
    end
  end

  ats_ram #(.WIDTH(ats_pkg::ROW_W), .DEPTH(TABLE_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (a_en_i),
    .raddr_i (a_addr_i),
    .rdata_o (a_raw)
  );

  ats_ram #(.WIDTH(ats_pkg::ROW_W), .DEPTH(TABLE_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (b_en_i),
    .raddr_i (b_addr_i),
    .rdata_o (b_raw)
  );

  // Unwritten rows: row one is an end row, all others relative, value zero
  always_comb begin
    if (a_vld_q) begin
      a_row_o = ats_pkg::row_t'(a_raw);
    end else begin
      a_row_o.kind  = a_one_q ? ats_pkg::KIND_END : ats_pkg::KIND_RELATIVE;
      a_row_o.value = '0;
    end
    if (b_vld_q) begin
      b_row_o = ats_pkg::row_t'(b_raw);
    end else begin
      b_row_o.kind  = b_one_q ? ats_pkg::KIND_END : ats_pkg::KIND_RELATIVE;
      b_row_o.value = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ats_step_unit.sv =====
// ---------------------------------------------------------------------------
// ats_step_unit
// Next-state logic: pointer update from the fetched row, flags, release
// counter and the clamped-jump flag for one operation.
// ---------------------------------------------------------------------------
`default_nettype none

module ats_step_unit (
  input  ats_pkg::op_e                      op_i,
  input  wire logic [ats_pkg::REL_W-1:0]    release_frames_i,
  input  wire logic [ats_pkg::LEN_W-1:0]    len_i,
  input  wire logic [ats_pkg::LEN_W-1:0]    p1_i,
  input  ats_pkg::row_t                     row_i,
  input  ats_pkg::seq_state_t               st_i,
  output ats_pkg::seq_state_t               st_o,
  output logic                              bad_o
);

  localparam int unsigned CW = ats_pkg::CALC_W;

  logic signed [CW-1:0] len_s, p1_s, tgt_s, np_s;
  logic                 tgt_bad;
  logic                 halted;

  // Jump target, clamped to the last row in use
  always_comb begin
    len_s   = $signed({1'b0, len_i});
    p1_s    = $signed({1'b0, p1_i});
    tgt_s   = $signed({2'b00, row_i.value[7:0]});
    tgt_bad = 1'b0;
    if (tgt_s >= len_s) begin
      tgt_bad = 1'b1;
      tgt_s   = len_s - CW'(1);
    end
  end

  assign halted = st_i.rel && (st_i.cnt == '0);

  // Operation decode
  always_comb begin
    st_o  = st_i;
    bad_o = 1'b0;
    np_s  = $signed({st_i.ptr[ats_pkg::PTR_W-1], st_i.ptr});
    case (op_i)
      ats_pkg::OP_START: begin
        np_s     = -CW'(1);
        st_o.cnt = '0;
        st_o.sus = 1'b0;
        st_o.rel = 1'b0;
      end
      ats_pkg::OP_STEP: begin
        if (!halted) begin
          np_s = p1_s;
          case (row_i.kind)
            ats_pkg::KIND_END: begin
              np_s = p1_s - CW'(1);
            end
            ats_pkg::KIND_GOTO: begin
              np_s  = tgt_s;
              bad_o = tgt_bad;
            end
            ats_pkg::KIND_SUSTAIN: begin
              st_o.sus = 1'b1;
              if (!st_i.rel) begin
                np_s  = tgt_s;
                bad_o = tgt_bad;
              end else begin
                np_s = p1_s + CW'(1);
              end
              if (np_s >= len_s) begin
                np_s = np_s - CW'(2);
              end
            end
            default: begin
              np_s = p1_s;
            end
          endcase
          if (st_i.cnt != '0) begin
            st_o.cnt = st_i.cnt - ats_pkg::REL_W'(1);
          end
        end
      end
      ats_pkg::OP_RELEASE: begin
        st_o.cnt = release_frames_i;
        st_o.rel = 1'b1;
      end
      default: begin
        // table write: state unchanged
      end
    endcase
    st_o.ptr = np_s[ats_pkg::PTR_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/arp_table_sequencer.sv =====
// Arpeggio table sequencer.
// Input channel (in_valid_i / in_stall_o) carries one operation per
// transaction: start, frame step, release, or a table row write. Every
// operation yields exactly one result transaction on the output channel
// (out_valid_o / out_stall_i): the current row, row pointer and flags as
// they stand after the operation.
// Configuration: cfg_valid_i / cfg_ready_o writes table_length; ready is
// always high. The user must make writes only while the block is idle;
// the block does not enforce it. Stage 1 takes a new transaction only
// when empty; the table sits in a RAM with registered reads. A step needs
// one read of the next row and, after the pointer update, one read of the
// row it lands on, and the pointer must be settled before the next
// operation's first read.
// Reset: pointer -1, flags and release counter clear, table_length 2; the
// table reads as row one end, all other rows relative with value zero, via
// per-row valid bits (no clearing pass).
// Output stall: the result register holds; the pipeline behind it fills
// and in_stall_o rises until the result is taken.
`default_nettype none

// ---------------------------------------------------------------------------
// arp_table_sequencer
// Top level: handshakes, pipeline stages, state registers and row store.
// ---------------------------------------------------------------------------
module arp_table_sequencer #(
  parameter int unsigned TABLE_DEPTH = ats_pkg::TABLE_DEPTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ats_pkg::LEN_W-1:0]   cfg_table_length_i,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [ats_pkg::OP_W-1:0]    op_i,
  input  wire logic [ats_pkg::IDX_W-1:0]   row_index_i,
  input  wire logic [ats_pkg::KIND_W-1:0]  row_kind_i,
  input  wire logic [ats_pkg::VAL_W-1:0]   row_value_i,
  input  wire logic [ats_pkg::REL_W-1:0]   release_frames_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [ats_pkg::KIND_W-1:0]       cur_kind_o,
  output logic [ats_pkg::VAL_W-1:0]        cur_value_o,
  output logic signed [ats_pkg::PTR_W-1:0] cur_index_o,
  output logic                             is_sustained_o,
  output logic                             is_released_o,
  output logic                             done_releasing_o,
  output logic                             bad_jump_o
);

`include "arp_table_sequencer_assert.svh"

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = ats_pkg::CALC_W;
  localparam int unsigned LW = ats_pkg::LEN_W;

  // Configuration register
  logic [LW-1:0] table_length_q;
  logic [LW-1:0] len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= ats_pkg::LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      table_length_q <= cfg_table_length_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Effective length, saturated to 1..TABLE_DEPTH
  always_comb begin
    if (table_length_q == '0) begin
      len = LW'(1);
    end else if (table_length_q > LW'(TABLE_DEPTH)) begin
      len = LW'(TABLE_DEPTH);
    end else begin
      len = table_length_q;
    end
  end

  // Handshake and stage control
  logic in_acc, s1_go, s2_go;
  logic s1_valid_q, s2_valid_q, out_valid_q;

  assign in_stall_o = s1_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s2_go      = s2_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_go      = s1_valid_q && (!s2_valid_q || s2_go);

  ats_pkg::seq_state_t st_q, st_d;

  // Next-row pointer at accept: advance and hold at the last row
  logic signed [CW-1:0] p1_c;
  logic [LW-1:0]        p1;

  always_comb begin
    p1_c = $signed({st_q.ptr[ats_pkg::PTR_W-1], st_q.ptr}) + CW'(1);
    if (p1_c >= $signed({1'b0, len})) begin
      p1_c = $signed({1'b0, len}) - CW'(1);
    end
    p1 = p1_c[LW-1:0];
  end

  // Stage 1 transaction registers
  ats_pkg::op_e                 s1_op_q;
  logic [ats_pkg::IDX_W-1:0]    s1_idx_q;
  ats_pkg::row_t                s1_row_q;
  logic [ats_pkg::REL_W-1:0]    s1_rel_q;
  logic [LW-1:0]                s1_p1_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q        <= ats_pkg::op_e'(op_i);
      s1_idx_q       <= row_index_i;
      s1_row_q.kind  <= row_kind_i;
      s1_row_q.value <= row_value_i;
      s1_rel_q       <= release_frames_i;
      s1_p1_q        <= p1;
    end
  end

  // Row store
  ats_pkg::row_t  row_a, row_b;
  logic           wr_en;
  logic [AW-1:0]  b_addr;

  assign wr_en  = s1_go && (s1_op_q == ats_pkg::OP_WRITE) && ({1'b0, s1_idx_q} < len);
  assign b_addr = st_d.ptr[AW-1:0];

  ats_row_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (wr_en),
    .waddr_i  (s1_idx_q[AW-1:0]),
    .wdata_i  (s1_row_q),
    .a_en_i   (in_acc),
    .a_addr_i (p1[AW-1:0]),
    .a_row_o  (row_a),
    .b_en_i   (s1_go),
    .b_addr_i (b_addr),
    .b_row_o  (row_b)
  );

  // Next state
  logic step_bad;

  ats_step_unit u_step (
    .op_i             (s1_op_q),
    .release_frames_i (s1_rel_q),
    .len_i            (len),
    .p1_i             (s1_p1_q),
    .row_i            (row_a),
    .st_i             (st_q),
    .st_o             (st_d),
    .bad_o            (step_bad)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.ptr <= '1;
      st_q.sus <= 1'b0;
      st_q.rel <= 1'b0;
      st_q.cnt <= '0;
    end else if (s1_go) begin
      st_q <= st_d;
    end
  end

  // Stage 2: status after the operation, write forwarding
  ats_pkg::seq_state_t s2_st_q;
  ats_pkg::row_t       s2_wrow_q;
  logic                s2_bad_q, s2_neg_q, s2_fwd_q;

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_st_q   <= st_d;
      s2_bad_q  <= step_bad;
      s2_neg_q  <= st_d.ptr[ats_pkg::PTR_W-1];
      s2_wrow_q <= s1_row_q;   // kept here, stage 1 may take a new transaction
      s2_fwd_q  <= wr_en && !st_q.ptr[ats_pkg::PTR_W-1]
                   && (st_q.ptr[ats_pkg::IDX_W-1:0] == s1_idx_q);
    end
  end

  // Valid flags of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        s2_valid_q <= 1'b1;
      end else if (s2_go) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  ats_pkg::row_t cur_row;

  always_comb begin
    if (s2_neg_q) begin
      cur_row.kind  = ats_pkg::KIND_ABSOLUTE;
      cur_row.value = '0;
    end else if (s2_fwd_q) begin
      cur_row = s2_wrow_q;
    end else begin
      cur_row = row_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      cur_kind_o       <= cur_row.kind;
      cur_value_o      <= cur_row.value;
      cur_index_o      <= $signed(s2_st_q.ptr);
      is_sustained_o   <= s2_st_q.sus;
      is_released_o    <= s2_st_q.rel;
      done_releasing_o <= (s2_st_q.cnt == '0);
      bad_jump_o       <= s2_bad_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  `ATS_ASSERT_NXT(a_acc_to_s1, in_acc, s1_valid_q, "accepted transaction lost")
  `ATS_ASSERT_IMP(a_s1_blocked, s2_valid_q && !s2_go, !s1_go, "stage 1 overran stage 2")
  `ATS_ASSERT_IMP(a_ptr_range, 1'b1,
                  (st_q.ptr == '1) || ({1'b0, st_q.ptr} < CW'(TABLE_DEPTH)),
                  "row pointer out of range")
  `ATS_ASSERT_NXT(a_halt_hold,
                  s1_go && (s1_op_q == ats_pkg::OP_STEP) && st_q.rel && (st_q.cnt == '0),
                  $stable(st_q.ptr), "step moved pointer after release finished")
  `ATS_ASSERT_IMP(a_bad_step, s1_go && (s1_op_q != ats_pkg::OP_STEP), !step_bad,
                  "clamped jump flagged outside a step")

endmodule

`default_nettype wire

// ===== verif/arp_table_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// arp_table_sequencer_tb
// Self-checking bench for the arpeggio table sequencer. A short directed
// table covers the reset table, end, goto and sustain rows, clamped jumps,
// length saturation, ignored writes, unknown kinds and zero release. After
// it come random tunes (start, row writes, frame steps, release) with some
// noise, over several table lengths and idling patterns. Every result
// transaction is compared field by field against a state predictor kept in
// the bench, or for typed directed rows against the row's expected state.
// ---------------------------------------------------------------------------
module arp_table_sequencer_tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 150;
  localparam int unsigned PHASE_ITEMS    = 160;
  localparam int unsigned N_DIRECTED     = 31;
  localparam int unsigned IW = ats_pkg::IDX_W;
  localparam int unsigned KW = ats_pkg::KIND_W;
  localparam int unsigned VW = ats_pkg::VAL_W;
  localparam int unsigned RW = ats_pkg::REL_W;
  localparam int unsigned LW = ats_pkg::LEN_W;
  localparam int unsigned PW = ats_pkg::PTR_W;
  localparam logic [KW-1:0] KIND_SPARE = 3'd7;  // unused code, steps as a plain row
  localparam logic [PW-1:0] PTR_NONE   = 9'h1FF; // pointer at minus one

  // One operation as offered on the input channel
  typedef struct packed {
    ats_pkg::op_e  op;
    logic [IW-1:0] idx;
    logic [KW-1:0] kind;
    logic [VW-1:0] val;
    logic [RW-1:0] rel;
  } op_item_t;

  // One result transaction
  typedef struct packed {
    logic [KW-1:0] kind;
    logic [VW-1:0] value;
    logic [PW-1:0] index;
    logic          sustained;
    logic          released;
    logic          done;
    logic          bad_jump;
  } arp_state_t;

  // Directed row: either a table_length write (length in item.val) or an op
  typedef struct packed {
    logic       cfg;
    logic       typed;
    op_item_t   item;
    arp_state_t exp;
  } dir_row_t;

  localparam arp_state_t E_IDLE =
    '{ats_pkg::KIND_ABSOLUTE, 16'h0, PTR_NONE, 1'b0, 1'b0, 1'b1, 1'b0};
  localparam arp_state_t E_ROW0 =
    '{ats_pkg::KIND_RELATIVE, 16'h0, 9'd0, 1'b0, 1'b0, 1'b1, 1'b0};
  localparam arp_state_t E_HELD =
    '{ats_pkg::KIND_RELATIVE, 16'h0, 9'd0, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam arp_state_t E_NONE = '0;

  // DUT signals
  logic              clk   = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LW-1:0]     cfg_len = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  op_item_t          in_item = '{ats_pkg::OP_START, '0, '0, '0, '0};
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KW-1:0]     cur_kind;
  logic [VW-1:0]     cur_value;
  logic signed [PW-1:0] cur_index;
  logic              is_sustained, is_released, done_releasing, bad_jump;

  // Predictor state
  int                tbl_len;
  int                ptr;
  bit                sus_f, rel_f;
  int                cnt;
  logic [KW-1:0]     kind_mem [ats_pkg::TABLE_DEPTH];
  logic [VW-1:0]     val_mem  [ats_pkg::TABLE_DEPTH];
  arp_state_t        owed_state_q [$];

  // Bench control and statistics
  int       send_pct  = 0;
  int       stall_pct = 0;
  int       hold_req  = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       idle_cycles = 0;
  int       n_errors = 0, n_items = 0, n_results = 0;
  int       n_steps = 0, n_writes = 0, n_bad = 0, n_cfg = 0;
  dir_row_t directed_tab [N_DIRECTED];

  // Clock
  always #5 clk = ~clk;

  arp_table_sequencer i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_table_length_i (cfg_len),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .op_i               (in_item.op),
    .row_index_i        (in_item.idx),
    .row_kind_i         (in_item.kind),
    .row_value_i        (in_item.val),
    .release_frames_i   (in_item.rel),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .cur_kind_o         (cur_kind),
    .cur_value_o        (cur_value),
    .cur_index_o        (cur_index),
    .is_sustained_o     (is_sustained),
    .is_released_o      (is_released),
    .done_releasing_o   (done_releasing),
    .bad_jump_o         (bad_jump)
  );

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Rows in use, saturated to 1..TABLE_DEPTH
  function automatic int eff_len();
    if (tbl_len < 1) return 1;
    if (tbl_len > ats_pkg::TABLE_DEPTH) return ats_pkg::TABLE_DEPTH;
    return tbl_len;
  endfunction

  // Jump target from the low byte, clamped to the last row
  function automatic int jump_row(input logic [VW-1:0] v, input int len,
                                  inout logic bad);
    int t;
    t = int'(v[7:0]);
    if (t >= len) begin
      bad = 1'b1;
      t   = len - 1;
    end
    return t;
  endfunction

  function automatic void reset_arp_state();
    tbl_len = int'(ats_pkg::LEN_RESET);
    ptr     = -1;
    sus_f   = 1'b0;
    rel_f   = 1'b0;
    cnt     = 0;
    foreach (kind_mem[i]) begin
      kind_mem[i] = ats_pkg::KIND_RELATIVE;
      val_mem[i]  = '0;
    end
    kind_mem[1] = ats_pkg::KIND_END;
  endfunction

  // Applies one operation and returns the state the block should report
  function automatic arp_state_t arp_apply_op(input op_item_t it);
    arp_state_t s;
    int         len;
    logic       bad;
    len = eff_len();
    bad = 1'b0;
    case (it.op)
      ats_pkg::OP_START: begin
        ptr   = -1;
        cnt   = 0;
        sus_f = 1'b0;
        rel_f = 1'b0;
      end
      ats_pkg::OP_STEP: begin
        // stepping stops once release has run out
        if (!(rel_f && cnt == 0)) begin
          ptr = ptr + 1;
          if (ptr >= len) ptr = len - 1;
          case (kind_mem[ptr])
            ats_pkg::KIND_END:  ptr = ptr - 1;
            ats_pkg::KIND_GOTO: ptr = jump_row(val_mem[ptr], len, bad);
            ats_pkg::KIND_SUSTAIN: begin
              sus_f = 1'b1;
              if (!rel_f) ptr = jump_row(val_mem[ptr], len, bad);
              else ptr = ptr + 1;
              if (ptr >= len) ptr = ptr - 2;
            end
            default: ;
          endcase
          if (cnt > 0) cnt = cnt - 1;
        end
      end
      ats_pkg::OP_RELEASE: begin
        cnt   = int'(it.rel);
        rel_f = 1'b1;
      end
      default: begin
        if (it.idx < len) begin
          kind_mem[it.idx] = it.kind;
          val_mem[it.idx]  = it.val;
        end
      end
    endcase
    if (ptr < 0) begin
      s.kind  = ats_pkg::KIND_ABSOLUTE;
      s.value = '0;
    end else begin
      s.kind  = kind_mem[ptr];
      s.value = val_mem[ptr];
    end
    s.index     = ptr[PW-1:0];
    s.sustained = sus_f;
    s.released  = rel_f;
    s.done      = (cnt == 0);
    s.bad_jump  = bad;
    return s;
  endfunction

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_errors < 50)
      $display("[%0t] mismatch, result %0d, %s: got %0h, want %0h",
               $time, n_results, what, got, want);
    n_errors++;
  endtask

  task automatic check_result();
    arp_state_t want;
    if (owed_state_q.size() == 0) begin
      report_mismatch("result with nothing owed", cur_index, 0);
    end else begin
      want = owed_state_q.pop_front();
      if (cur_kind !== want.kind)
        report_mismatch("cur_kind", cur_kind, want.kind);
      if (cur_value !== want.value)
        report_mismatch("cur_value", cur_value, want.value);
      if (cur_index !== want.index)
        report_mismatch("cur_index", cur_index, want.index);
      if (is_sustained !== want.sustained)
        report_mismatch("is_sustained", is_sustained, want.sustained);
      if (is_released !== want.released)
        report_mismatch("is_released", is_released, want.released);
      if (done_releasing !== want.done)
        report_mismatch("done_releasing", done_releasing, want.done);
      if (bad_jump !== want.bad_jump)
        report_mismatch("bad_jump", bad_jump, want.bad_jump);
      if (want.bad_jump) n_bad++;
    end
    n_results++;
  endtask

  // Receiver: check accepted transactions, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: cycles in which neither channel moves a transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  // Offer one operation; valid is left high so back-to-back items keep it up
  task automatic send_op(input op_item_t it, input logic typed, input arp_state_t given);
    arp_state_t s;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    s = arp_apply_op(it);
    owed_state_q.push_back(typed ? given : s);
    n_items++;
    if (it.op == ats_pkg::OP_STEP) n_steps++;
    if (it.op == ats_pkg::OP_WRITE) n_writes++;
  endtask

  // Lower valid and wait until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (owed_state_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input logic [LW-1:0] len);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_len   <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tbl_len = int'(len);
    n_cfg++;
  endtask

  // Random item; indexes and jump targets mostly land inside the table
  function automatic op_item_t random_item(input int len);
    op_item_t it;
    it.op   = ats_pkg::op_e'($urandom_range(3));
    it.idx  = ($urandom_range(99) < 80) ? IW'($urandom_range(len - 1))
                                        : IW'($urandom_range(255));
    it.kind = ($urandom_range(99) < 60)
              ? KW'($urandom_range(ats_pkg::KIND_SUSTAIN, ats_pkg::KIND_END))
              : KW'($urandom_range(7));
    it.val  = VW'($urandom);
    if ($urandom_range(99) < 70) it.val[7:0] = 8'($urandom_range(len - 1));
    it.rel  = ($urandom_range(99) < 75) ? RW'($urandom_range(12)) : RW'($urandom);
    return it;
  endfunction

  // One well-formed tune: start, a few row writes, steps, maybe a release
  task automatic play_tune(input int len);
    op_item_t it;
    int       n;
    it    = random_item(len);
    it.op = ats_pkg::OP_START;
    send_op(it, 1'b0, E_NONE);
    n = $urandom_range(4, 1);
    repeat (n) begin
      it    = random_item(len);
      it.op = ats_pkg::OP_WRITE;
      send_op(it, 1'b0, E_NONE);
    end
    n = $urandom_range(12, 2);
    repeat (n) begin
      it    = random_item(len);
      it.op = ats_pkg::OP_STEP;
      send_op(it, 1'b0, E_NONE);
    end
    if ($urandom_range(99) < 60) begin
      it    = random_item(len);
      it.op = ats_pkg::OP_RELEASE;
      send_op(it, 1'b0, E_NONE);
      n = $urandom_range(10, 1);
      repeat (n) begin
        it    = random_item(len);
        it.op = ats_pkg::OP_STEP;
        send_op(it, 1'b0, E_NONE);
      end
    end
  endtask

  initial begin
    int          lens [8];
    int          phase_end;
    int          tune_no;
    int          n;
    op_item_t    it;

    // Directed table: cfg, typed, item, expected state
    directed_tab = '{
      // reset table: row 0 relative, row 1 end backs up
      '{1'b0, 1'b1, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_ROW0},
      '{1'b0, 1'b1, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_ROW0},
      '{1'b0, 1'b1, '{ats_pkg::OP_START, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_IDLE},
      // write beyond the length is dropped
      '{1'b0, 1'b1, '{ats_pkg::OP_WRITE, 8'd5, ats_pkg::KIND_GOTO, 16'h0000, 12'h000},
        E_IDLE},
      '{1'b1, 1'b0, '{ats_pkg::OP_START, 8'd0, ats_pkg::KIND_RELATIVE, 16'd256, 12'h000},
        E_NONE},
      '{1'b0, 1'b1, '{ats_pkg::OP_WRITE, 8'd255, ats_pkg::KIND_ABSOLUTE, 16'hFFFF, 12'h000},
        E_IDLE},
      '{1'b0, 1'b1, '{ats_pkg::OP_WRITE, 8'd0, ats_pkg::KIND_END, 16'h8000, 12'h000},
        E_IDLE},
      // end on row zero goes back to minus one
      '{1'b0, 1'b1, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_IDLE},
      '{1'b0, 1'b0, '{ats_pkg::OP_WRITE, 8'd0, ats_pkg::KIND_GOTO, 16'hFFFF, 12'h000},
        E_NONE},
      '{1'b0, 1'b0, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_NONE},
      // hold at the last row
      '{1'b0, 1'b0, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_NONE},
      '{1'b0, 1'b0, '{ats_pkg::OP_WRITE, 8'd1, KIND_SPARE, 16'h1234, 12'h000},
        E_NONE},
      '{1'b0, 1'b1, '{ats_pkg::OP_START, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_IDLE},
      '{1'b0, 1'b1, '{ats_pkg::OP_WRITE, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_IDLE},
      '{1'b0, 1'b1, '{ats_pkg::OP_WRITE, 8'd2, ats_pkg::KIND_SUSTAIN, 16'h0001, 12'h000},
        E_IDLE},
      // sustain loops back to row 1 until release
      '{1'b0, 1'b0, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_NONE},
      '{1'b0, 1'b0, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_NONE},
      '{1'b0, 1'b0, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_NONE},
      '{1'b0, 1'b0, '{ats_pkg::OP_RELEASE, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'hFFF},
        E_NONE},
      '{1'b0, 1'b0, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_NONE},
      // length zero saturates to one; pointer beyond it is pulled back
      '{1'b1, 1'b0, '{ats_pkg::OP_START, 8'd0, ats_pkg::KIND_RELATIVE, 16'd0, 12'h000},
        E_NONE},
      '{1'b0, 1'b0, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_NONE},
      // zero release stops stepping at once
      '{1'b0, 1'b1, '{ats_pkg::OP_RELEASE, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_HELD},
      '{1'b0, 1'b1, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_HELD},
      '{1'b1, 1'b0, '{ats_pkg::OP_START, 8'd0, ats_pkg::KIND_RELATIVE, 16'd3, 12'h000},
        E_NONE},
      '{1'b0, 1'b1, '{ats_pkg::OP_START, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_IDLE},
      // goto past the length is clamped and flagged
      '{1'b0, 1'b0, '{ats_pkg::OP_WRITE, 8'd0, ats_pkg::KIND_GOTO, 16'h00FE, 12'h000},
        E_NONE},
      '{1'b0, 1'b0, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_NONE},
      '{1'b0, 1'b0, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_NONE},
      // released sustain on the last row falls back one row
      '{1'b0, 1'b0, '{ats_pkg::OP_RELEASE, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h003},
        E_NONE},
      '{1'b0, 1'b0, '{ats_pkg::OP_STEP, 8'd0, ats_pkg::KIND_RELATIVE, 16'h0000, 12'h000},
        E_NONE}
    };
    lens = '{2, 1, 256, 3, 0, 511, $urandom_range(16, 4), $urandom_range(256, 1)};

    // Reset
    reset_arp_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    foreach (directed_tab[i]) begin
      if (directed_tab[i].cfg)
        write_length(directed_tab[i].item.val[LW-1:0]);
      else
        send_op(directed_tab[i].item, directed_tab[i].typed, directed_tab[i].exp);
    end

    // Random phases: table length and idling pattern change per phase
    for (int ph = 0; ph < 8; ph++) begin
      write_length(LW'(lens[ph]));
      case (ph % 4)
        0: begin send_pct = 0;  stall_pct <= 0;  end
        1: begin send_pct = 74; stall_pct <= 0;  end
        2: begin send_pct = 0;  stall_pct <= 74; end
        default: begin send_pct = 32; stall_pct <= 32; end
      endcase
      // long receiver hold while items keep coming: the block backs up
      if (ph == 0) hold_req <= hold_req + 1;
      tune_no   = 0;
      phase_end = n_items + PHASE_ITEMS;
      while (n_items < phase_end) begin
        if ((ph == 3 && tune_no == 5) || $urandom_range(99) < 3) wait_drained();
        if ($urandom_range(99) < 15) begin
          n = $urandom_range(6, 1);
          repeat (n) begin
            it = random_item(eff_len());
            send_op(it, 1'b0, E_NONE);
          end
        end else begin
          play_tune(eff_len());
        end
        tune_no++;
      end
    end

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    while (owed_state_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (owed_state_q.size() != 0)
      report_mismatch("results still owed", owed_state_q.size(), 0);

    $display("Ran %0d operations (%0d frame steps, %0d row writes) over %0d length settings,",
             n_items, n_steps, n_writes, n_cfg);
    $display("checked %0d results, %0d of them clamped jumps; %0d mismatches.",
             n_results, n_bad, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ats_pkg.sv
rtl/ats_ram.sv
rtl/ats_row_store.sv
rtl/ats_step_unit.sv
rtl/arp_table_sequencer.sv
verif/arp_table_sequencer_tb.sv
